/* rtl/point_to_screen_projection_core_defines.svh */
// assertion macros for the projection core checker
`ifndef POINT_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH
`define POINT_TO_SCREEN_PROJECTION_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define PSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/psp_pkg.sv */
`timescale 1ns / 1ps
package psp_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned MADDR_W  = 5;
    localparam int unsigned KIND_W   = 2;

    localparam logic [KIND_W-1:0] KIND_STORED    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd2;

    localparam logic [1:0] REG_VIEW_X      = 2'd0;
    localparam logic [1:0] REG_VIEW_Y      = 2'd1;
    localparam logic [1:0] REG_VIEW_WIDTH  = 2'd2;
    localparam logic [1:0] REG_VIEW_HEIGHT = 2'd3;

    localparam logic FUNC_LOAD      = 1'b0;
    localparam logic FUNC_TRANSFORM = 1'b1;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7fffffff;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

endpackage

/* rtl/psp_ram.sv */
`timescale 1ns / 1ps
module psp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* rtl/psp_div.sv */
`timescale 1ns / 1ps
// restoring signed divider, one quotient bit per cycle, truncates toward zero
module psp_div
    import psp_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    localparam int unsigned NW = 32 + FRAC_BITS;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [33:0]   trial;
    logic [NW:0]   sq;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
            d_next    = den[31] ? 32'(-den) : 32'(den);
            neg_next  = num[31] ^ den[31];
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, q_reg[NW-1]} - {2'b00, d_reg};
            if (!trial[33])
                rem_next = trial[32:0];
            else
                rem_next = {rem_reg[31:0], q_reg[NW-1]};
            q_next   = {q_reg[NW-2:0], ~trial[33]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign sq   = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign done = done_reg;
    assign quot = sat32(72'(signed'(sq)));
endmodule

/* rtl/psp_mac.sv */
`timescale 1ns / 1ps
// one matrix word times one vector element per cycle, floor-shifted, summed
module psp_mac
    import psp_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               clr,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] sum_sat
);
    logic signed [63:0] prod_reg;
    logic               pv_reg;
    logic signed [65:0] acc_reg;
    logic signed [63:0] shifted;

    assign shifted = prod_reg >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        pv_reg   <= en;
        // clr restarts the sum with the first product of a row
        if (clr)
            acc_reg <= 66'(shifted);
        else if (pv_reg)
            acc_reg <= acc_reg + 66'(shifted);
    end

    assign sum_sat = sat32(72'(acc_reg));
endmodule

/* rtl/point_to_screen_projection_core.sv */
`timescale 1ns / 1ps
// point to screen projection core
// s_axis carries one item: a matrix word load (tuser 0) or a point transform
// (tuser 1). m_axis returns exactly one item for each accepted input item,
// with the result kind on tuser.
// load items store one word in the 32-word matrix memory; the result passes
// through the load and out states into the output register. a transform
// walks both 4x4 matrices through one memory read port and one multiplier,
// one word per cycle, forms c = P * (W * p), then divides x, y and z by w on
// one shared bit-serial divider, one coordinate after another, and maps the
// quotients to the viewport before the out state; w of zero skips the
// divides and returns kind rejected.
// one item is worked on at a time; the result sits in an output register and
// s_axis_tready stays low until it leaves, so the next item is accepted at
// the earliest in the cycle the result is taken; a stalled receiver stalls
// the input.
// reset restores the viewport registers to 0, 0, 1024, 768 and idles the
// sequencer; matrix words are undefined until loaded.
// configuration writes are taken at any time and must come while idle.
module point_to_screen_projection_core
    import psp_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index(4:0), entry_value(36:5), point_x(68:37),
    // point_y(100:69), point_z(132:101), zero fill
    input  logic [135:0] s_axis_tdata,
    // func(0)
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // screen_x(31:0), screen_y(63:32), screen_depth(95:64)
    output logic [95:0]  m_axis_tdata,
    // result_kind(1:0)
    output logic [1:0]   m_axis_tuser,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data
);
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOAD   = 7'b0000010,
        ST_WORLD  = 7'b0000100,
        ST_PROJ   = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_VIEW   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    state_t state_reg, state_next;

    logic [11:0] vx_reg, vy_reg;
    logic [12:0] vw_reg, vh_reg;

    logic [5:0]  step_reg, step_next;     // feed step within a matrix pass
    logic [1:0]  dsel_reg, dsel_next;     // which coordinate is being divided
    logic        dstart_reg, dstart_next;

    logic signed [31:0] pt_reg [4];
    logic signed [31:0] ev_reg [4];
    logic signed [31:0] cv_reg [4];
    logic signed [31:0] nv_reg [3];
    logic signed [31:0] sx_reg, sy_reg, sd_reg;
    logic [1:0]         kind_reg;
    logic               ov_reg;

    // memory port
    logic        ram_we;
    logic [4:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;

    psp_ram #(.WIDTH(32), .DEPTH(32)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // feed schedule: step s reads word c*4+r (r = s[3:2], c = s[1:0]) row by row;
    // the read data, the registered product and the accumulated sum follow in turn
    logic [1:0] rd_row, rd_col, v_col;
    logic [5:0] vstep;
    logic       feed_en, mac_clr;
    logic signed [31:0] mac_b, mac_sum;

    assign rd_row = step_reg[3:2];
    assign rd_col = step_reg[1:0];
    assign vstep  = step_reg - 6'd1;
    assign v_col  = vstep[1:0];
    assign feed_en = (state_reg == ST_WORLD || state_reg == ST_PROJ)
                     && step_reg >= 6'd1 && step_reg <= 6'd16;
    // clear the sum as the first product of each row lands
    assign mac_clr = (state_reg == ST_WORLD || state_reg == ST_PROJ)
                     && step_reg >= 6'd2 && step_reg[1:0] == 2'd2 && step_reg <= 6'd14;

    always_comb
    begin
        if (state_reg == ST_WORLD)
            mac_b = pt_reg[v_col];
        else
            mac_b = ev_reg[v_col];
    end

    logic mac_en;
    assign mac_en = feed_en;

    psp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk(clk), .clr(mac_clr), .en(mac_en), .a(ram_rdata), .b(mac_b),
        .sum_sat(mac_sum)
    );

    // divider
    logic               div_done;
    logic signed [31:0] div_q;

    psp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart_reg), .num(cv_reg[dsel_reg]),
        .den(cv_reg[3]), .done(div_done), .quot(div_q)
    );

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!ov_reg || m_axis_tready);

    assign ram_we    = in_acc && s_axis_tuser == FUNC_LOAD;
    assign ram_waddr = s_axis_tdata[4:0];
    assign ram_wdata = s_axis_tdata[36:5];
    assign ram_raddr = {state_reg == ST_PROJ, rd_col, rd_row};

    // sum lands the cycle after its fourth product, at steps 6, 10, 14, 18
    logic       row_done;
    logic [1:0] row_idx;
    logic [5:0] rstep;
    assign rstep    = step_reg - 6'd6;
    assign row_idx  = rstep[3:2];
    assign row_done = (state_reg == ST_WORLD || state_reg == ST_PROJ)
                      && step_reg >= 6'd6 && step_reg[1:0] == 2'd2;

    // viewport math
    logic signed [47:0] spx, spy;
    logic signed [71:0] vxs, vys, dz;
    assign spx = (48'(nv_reg[0]) + 48'(ONE)) * 48'($signed({1'b0, vw_reg}));
    assign spy = (48'(nv_reg[1]) + 48'(ONE)) * 48'($signed({1'b0, vh_reg}));
    assign vxs = 72'(spx >>> 1) + (72'($signed({1'b0, vx_reg})) <<< FRAC_BITS);
    assign vys = 72'(spy >>> 1) + (72'($signed({1'b0, vy_reg})) <<< FRAC_BITS);
    assign dz  = (72'(nv_reg[2]) + 72'(ONE)) >>> 1;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        dsel_next   = dsel_reg;
        dstart_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    step_next = '0;
                    if (s_axis_tuser == FUNC_LOAD)
                        state_next = ST_LOAD;
                    else
                        state_next = ST_WORLD;
                end
            end
            ST_LOAD:
                state_next = ST_OUT;
            ST_WORLD, ST_PROJ:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd18)
                begin
                    step_next = '0;
                    if (state_reg == ST_WORLD)
                        state_next = ST_PROJ;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == 6'd0)
                begin
                    step_next = 6'd1;
                    if (cv_reg[3] == 32'sd0)
                        state_next = ST_OUT;
                    else
                    begin
                        dsel_next   = 2'd0;
                        dstart_next = 1'b1;
                    end
                end
                else if (div_done)
                begin
                    if (dsel_reg == 2'd2)
                        state_next = ST_VIEW;
                    else
                    begin
                        dsel_next   = dsel_reg + 2'd1;
                        dstart_next = 1'b1;
                    end
                end
            end
            ST_VIEW:
                state_next = ST_OUT;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            dsel_reg   <= '0;
            dstart_reg <= 1'b0;
            ov_reg     <= 1'b0;
            vx_reg     <= 12'd0;
            vy_reg     <= 12'd0;
            vw_reg     <= 13'd1024;
            vh_reg     <= 13'd768;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            dsel_reg   <= dsel_next;
            dstart_reg <= dstart_next;
            if (state_reg == ST_OUT)
                ov_reg <= 1'b1;
            else if (out_acc)
                ov_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VIEW_X:      vx_reg <= cfg_data[11:0];
                    REG_VIEW_Y:      vy_reg <= cfg_data[11:0];
                    REG_VIEW_WIDTH:  vw_reg <= cfg_data;
                    REG_VIEW_HEIGHT: vh_reg <= cfg_data;
                    default:         vx_reg <= vx_reg;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pt_reg[0] <= s_axis_tdata[68:37];
            pt_reg[1] <= s_axis_tdata[100:69];
            pt_reg[2] <= s_axis_tdata[132:101];
            pt_reg[3] <= ONE;
        end
        if (row_done && state_reg == ST_WORLD)
            ev_reg[row_idx] <= mac_sum;
        if (row_done && state_reg == ST_PROJ)
            cv_reg[row_idx] <= mac_sum;
        if (div_done)
            nv_reg[dsel_reg] <= div_q;
        if (state_reg == ST_LOAD)
        begin
            kind_reg <= KIND_STORED;
            sx_reg <= '0; sy_reg <= '0; sd_reg <= '0;
        end
        else if (state_reg == ST_DIV && step_reg == 6'd0 && cv_reg[3] == 32'sd0)
        begin
            kind_reg <= KIND_REJECTED;
            sx_reg <= '0; sy_reg <= '0; sd_reg <= '0;
        end
        else if (state_reg == ST_VIEW)
        begin
            kind_reg <= KIND_PROJECTED;
            sx_reg <= sat32(vxs);
            sy_reg <= sat32(vys);
            sd_reg <= sat32(dz);
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {sd_reg, sy_reg, sx_reg};
    assign m_axis_tuser  = kind_reg;
endmodule

/* rtl/psp_checker.sv */
`timescale 1ns / 1ps
`include "point_to_screen_projection_core_defines.svh"
module psp_checker
    import psp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    `PSP_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PSP_ASSERT_IMPL(a_kind, clk, rst_n, m_axis_tvalid, m_axis_tuser <= KIND_REJECTED)
    `PSP_ASSERT_IMPL(a_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser != KIND_PROJECTED, m_axis_tdata == 96'd0)
    `PSP_ASSERT_NEXT(a_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind point_to_screen_projection_core psp_checker u_psp_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

/* bench/point_to_screen_projection_core_tb.sv */
`timescale 1ns / 1ps
module point_to_screen_projection_core_tb;
    import psp_pkg::*;

    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 250;

    typedef struct packed {
        logic                func;
        logic [4:0]          entry_index;
        logic signed [31:0]  entry_value;
        logic signed [31:0]  point_x;
        logic signed [31:0]  point_y;
        logic signed [31:0]  point_z;
    } psp_item_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [31:0]  sx;
        logic signed [31:0]  sy;
        logic signed [31:0]  sd;
    } screen_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // entry_index, entry_value, point_x, point_y, point_z, zero fill
    logic [135:0] s_axis_tdata;
    // func
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // screen_x, screen_y, screen_depth
    logic [95:0]  m_axis_tdata;
    // result_kind
    logic [1:0]   m_axis_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [12:0]  cfg_data;

    point_to_screen_projection_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow of the block: matrix store and viewport registers
    logic signed [31:0] matrix_shadow [32];
    logic [11:0]        origin_x;
    logic [11:0]        origin_y;
    logic [12:0]        size_w;
    logic [12:0]        size_h;

    psp_item_t      pending_items [$];
    screen_result_t expected_screen [$];
    int             mismatches;
    bit             failed;
    bit             no_idle;
    bit             hold_request;
    int             hold_left;
    bit             in_taken;
    int             quiet_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one stage: out = M * v, each product floored by the fraction bits
    function automatic void matrix_stage(int base, longint v [4], output longint o [4]);
        longint acc;
        longint m;
        for (int r = 0; r < 4; r++)
        begin
            acc = 0;
            for (int c = 0; c < 4; c++)
            begin
                m = longint'(matrix_shadow[base + c * 4 + r]);
                acc += (m * v[c]) >>> 16;
            end
            o[r] = clamp32(acc);
        end
    endfunction

    function automatic longint viewport_map(longint ndc, logic [11:0] org, logic [12:0] sz);
        longint span;
        span = ((ndc + 65536) * longint'({51'd0, sz})) >>> 1;
        return clamp32((longint'({52'd0, org}) <<< 16) + span);
    endfunction

    function automatic screen_result_t project_point(psp_item_t it);
        screen_result_t res;
        longint p [4];
        longint e [4];
        longint c [4];
        longint n [3];
        res = '0;
        if (it.func == FUNC_LOAD)
        begin
            matrix_shadow[it.entry_index] = it.entry_value;
            res.kind = KIND_STORED;
            return res;
        end
        p[0] = it.point_x;
        p[1] = it.point_y;
        p[2] = it.point_z;
        p[3] = 65536;
        matrix_stage(0, p, e);
        matrix_stage(16, e, c);
        if (c[3] == 0)
        begin
            res.kind = KIND_REJECTED;
            return res;
        end
        // division truncates toward zero
        for (int i = 0; i < 3; i++)
            n[i] = clamp32((c[i] * 65536) / c[3]);
        res.kind = KIND_PROJECTED;
        res.sx = viewport_map(n[0], origin_x, size_w);
        res.sy = viewport_map(n[1], origin_y, size_h);
        res.sd = clamp32((n[2] + 65536) >>> 1);
        return res;
    endfunction

    // stimulus builders
    function automatic psp_item_t load_word(int idx, logic signed [31:0] val);
        psp_item_t it;
        it = '0;
        it.func = FUNC_LOAD;
        it.entry_index = idx[4:0];
        it.entry_value = val;
        it.point_x = $urandom;
        it.point_y = $urandom;
        it.point_z = $urandom;
        return it;
    endfunction

    function automatic psp_item_t point_item(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z);
        psp_item_t it;
        it.func = FUNC_TRANSFORM;
        it.entry_index = $urandom;
        it.entry_value = $urandom;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        return it;
    endfunction

    // mostly a few units in Q16.16, sometimes the full range
    function automatic logic signed [31:0] rand_fixed();
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
            return $urandom;
        if (sel < 3)
            return $urandom_range(3) == 0 ? 32'sh0 : 32'sh00010000;
        return $signed($urandom_range(1048576)) - 32'sd524288;
    endfunction

    function automatic psp_item_t random_item();
        if ($urandom_range(99) < 20)
            return load_word($urandom_range(31), rand_fixed());
        return point_item(rand_fixed(), rand_fixed(), rand_fixed());
    endfunction

    // ---- sender: one item offered at a time from the pending queue ----
    always @(negedge clk)
    begin
        psp_item_t it;
        if (rst_n && !(s_axis_tvalid && !in_taken))
        begin
            if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 18))
            begin
                it = pending_items.pop_front();
                s_axis_tuser <= it.func;
                s_axis_tdata <= {3'b000, it.point_z, it.point_y, it.point_x,
                                 it.entry_value, it.entry_index};
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---- receiver: random stalls plus one long hold-off on request ----
    always @(negedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= 18);
    end

    // ---- monitor: predict on input accept, check on output accept ----
    always @(posedge clk)
    begin
        screen_result_t got;
        screen_result_t want;
        psp_item_t      seen;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_VIEW_X:      origin_x = cfg_data[11:0];
                REG_VIEW_Y:      origin_y = cfg_data[11:0];
                REG_VIEW_WIDTH:  size_w = cfg_data;
                REG_VIEW_HEIGHT: size_h = cfg_data;
            endcase
        end
        if (in_taken)
        begin
            seen.func = s_axis_tuser;
            seen.entry_index = s_axis_tdata[4:0];
            seen.entry_value = s_axis_tdata[36:5];
            seen.point_x = s_axis_tdata[68:37];
            seen.point_y = s_axis_tdata[100:69];
            seen.point_z = s_axis_tdata[132:101];
            expected_screen.push_back(project_point(seen));
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64]};
            if (expected_screen.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: kind %0d", got.kind);
            end
            else
            begin
                want = expected_screen.pop_front();
                if (got != want)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: kind %0d/%0d x %h/%h y %h/%h depth %h/%h",
                                 want.kind, got.kind, want.sx, got.sx,
                                 want.sy, got.sy, want.sd, got.sd);
                end
            end
        end
        // watchdog on cycles with no progress at all
        if (in_taken || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** point_to_screen_projection_core: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_viewport(logic [11:0] x, logic [11:0] y, logic [12:0] w, logic [12:0] h);
        write_reg(REG_VIEW_X, {1'b0, x});
        write_reg(REG_VIEW_Y, {1'b0, y});
        write_reg(REG_VIEW_WIDTH, w);
        write_reg(REG_VIEW_HEIGHT, h);
    endtask

    // waits until every queued item is sent and every expected result has come back
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_screen.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item());
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_LOAD;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_VIEW_X;
        cfg_data = '0;
        origin_x = 12'd0;
        origin_y = 12'd0;
        size_w = 13'd1024;
        size_h = 13'd768;
        for (int i = 0; i < 32; i++)
            matrix_shadow[i] = '0;
        mismatches = 0;
        failed = 1'b0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        in_taken = 1'b0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: world identity, projection with w taken from z,
        // so z of zero gives a rejected point
        for (int i = 0; i < 16; i++)
            pending_items.push_back(load_word(i, (i % 5 == 0) ? 32'sh00010000 : 32'sh0));
        for (int i = 0; i < 16; i++)
            pending_items.push_back(load_word(16 + i,
                (i == 0 || i == 5 || i == 10 || i == 11) ? 32'sh00010000 : 32'sh0));
        pending_items.push_back(point_item(32'sh00008000, -32'sh00004000, 32'sh00010000));
        pending_items.push_back(point_item(32'sh7fffffff, 32'sh7fffffff, 32'sh00000001));
        pending_items.push_back(point_item(32'sh80000000, 32'sh80000000, 32'sh80000000));
        pending_items.push_back(point_item(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        pending_items.push_back(point_item(32'sh00020000, 32'sh00030000, 32'sh0));
        pending_items.push_back(point_item(-32'sh00010000, 32'sh00010000, -32'sh00020000));
        // w row cleared entirely, then set to pass the point's w through
        pending_items.push_back(load_word(27, 32'sh0));
        pending_items.push_back(point_item(32'sh00010000, 32'sh00010000, 32'sh00010000));
        pending_items.push_back(load_word(31, 32'sh00010000));
        pending_items.push_back(point_item(32'sh00010000, 32'sh00020000, -32'sh00010000));
        pending_items.push_back(load_word(7, 32'sh80000000));
        pending_items.push_back(load_word(12, 32'sh7fffffff));
        pending_items.push_back(point_item(32'sh00010000, 32'sh00010000, 32'sh00010000));
        drain();

        // full viewport extremes
        set_viewport(12'd4095, 12'd4095, 13'd4096, 13'd4096);
        random_phase(220);
        drain();

        // one-by-one viewport at the origin, no idling on either side
        set_viewport(12'd0, 12'd0, 13'd1, 13'd1);
        no_idle = 1'b1;
        random_phase(220);
        drain();
        no_idle = 1'b0;

        // random viewport with a long receiver hold-off so the input backs up
        set_viewport($urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4096, 1), $urandom_range(4096, 1));
        hold_request = 1'b1;
        random_phase(220);
        drain();

        // zero size and all 13 size bits set
        set_viewport($urandom_range(4095), $urandom_range(4095), 13'd0, 13'h1fff);
        random_phase(220);
        drain();

        set_viewport($urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4096, 1), $urandom_range(4096, 1));
        random_phase(200);
        drain();

        if (!failed && expected_screen.size() == 0)
            $display("** point_to_screen_projection_core: PASSED **");
        else
            $display("** point_to_screen_projection_core: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/psp_pkg.sv
rtl/psp_ram.sv
rtl/psp_div.sv
rtl/psp_mac.sv
rtl/point_to_screen_projection_core.sv
rtl/psp_checker.sv
bench/point_to_screen_projection_core_tb.sv
